[hw/rtl/ifr_pkg.sv]
// shared types and constants for the image frame receiver
// no dependencies; imported by every module of the block
package ifr_pkg;

  localparam int unsigned AddrW       = 17;
  localparam int unsigned BufferBytes = 1 << AddrW;
  localparam int unsigned SizeW       = AddrW + 1;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QPtrW       = $clog2(QueueDepth);

  localparam logic [SizeW-1:0] LimitCap = SizeW'(BufferBytes);

  // result event codes
  localparam logic [2:0] EvNone     = 3'd0;
  localparam logic [2:0] EvHdrByte  = 3'd1;
  localparam logic [2:0] EvHdrOk    = 3'd2;
  localparam logic [2:0] EvPayload  = 3'd3;
  localparam logic [2:0] EvBadMagic = 3'd4;
  localparam logic [2:0] EvBadMode  = 3'd5;
  localparam logic [2:0] EvTooLarge = 3'd6;
  localparam logic [2:0] EvTimeout  = 3'd7;

  // framing bytes
  localparam logic [7:0] StartByte = 8'h45;
  localparam logic [7:0] MagicP    = 8'h50;
  localparam logic [7:0] MagicD    = 8'h44;

  // mode bytes
  localparam logic [7:0] ModeMono     = 8'd0;
  localparam logic [7:0] ModeColor    = 8'd1;
  localparam logic [7:0] ModePartMono = 8'd10;
  localparam logic [7:0] ModePartCol  = 8'd11;

  // configuration register indexes and reset values
  localparam logic CfgTimeout    = 1'b0;
  localparam logic CfgMaxPayload = 1'b1;
  localparam logic [15:0]      TimeoutReset    = 16'd5000;
  localparam logic [SizeW-1:0] MaxPayloadReset = SizeW'(77760);

  typedef struct packed {
    logic       is_tick;
    logic       is_start;
    logic [7:0] data;
  } item_t;

endpackage

[hw/rtl/ifr_front.sv]
// front part: accepts input beats, classifies them and queues them
// depends on ifr_pkg
module ifr_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          opcode_i,
  input  logic [7:0]    rx_byte_i,
  output logic          q_valid_o,
  output ifr_pkg::item_t q_item_o,
  input  logic          q_pop_i
);
  import ifr_pkg::*;

  item_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]     count_q, count_d;
  logic               push, pop;
  item_t              item_in;

  assign in_stall_o = (count_q == (QPtrW+1)'(QueueDepth));
  assign q_valid_o  = (count_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  assign push = in_valid_i & ~in_stall_o;
  assign pop  = q_pop_i & q_valid_o;

  always_comb begin
    item_in.is_tick  = opcode_i;
    item_in.is_start = ~opcode_i & (rx_byte_i == StartByte);
    item_in.data     = rx_byte_i;
  end

  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= item_in;
  end

endmodule

[hw/rtl/ifr_back.sv]
// back part: frame state machine, size check, timeout and output register
// depends on ifr_pkg
module ifr_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  input  ifr_pkg::item_t            q_item_i,
  output logic                      q_pop_o,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_index_i,
  input  logic [ifr_pkg::SizeW-1:0] cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                event_res_o,
  output logic [ifr_pkg::AddrW-1:0] payload_addr_o,
  output logic [7:0]                payload_data_o,
  output logic                      frame_done_o,
  output logic [15:0]               frame_width_o,
  output logic [15:0]               frame_height_o,
  output logic [7:0]                frame_mode_o,
  output logic [15:0]               frame_x_o,
  output logic [15:0]               frame_y_o,
  output logic [ifr_pkg::SizeW-1:0] payload_size_o
);
  import ifr_pkg::*;

  localparam logic [1:0] PhHunt    = 2'd0;
  localparam logic [1:0] PhHeader  = 2'd1;
  localparam logic [1:0] PhPayload = 2'd2;

  logic [1:0]       phase_q, phase_d;
  logic [3:0]       hidx_q, hidx_d;
  logic [7:0]       magic0_q, magic0_d, magic1_q, magic1_d;
  logic [15:0]      width_q, width_d, height_q, height_d;
  logic [7:0]       mode_q, mode_d;
  logic [15:0]      x_q, x_d, y_q, y_d;
  logic [SizeW-1:0] exp_q, exp_d, rcv_q, rcv_d;
  logic [16:0]      idle_q, idle_d;
  logic [31:0]      prod_q;
  logic [15:0]      timeout_q;
  logic [SizeW-1:0] maxpay_q;

  logic             out_valid_q;
  logic [2:0]       ev_q;
  logic [AddrW-1:0] addr_q;
  logic [7:0]       data_q;
  logic             done_q;
  logic [15:0]      fw_q, fh_q, fx_q, fy_q;
  logic [7:0]       fm_q;
  logic [SizeW-1:0] size_q;

  logic             pop;
  logic [2:0]       ev;
  logic [AddrW-1:0] addr;
  logic [7:0]       data;
  logic             done;
  logic [7:0]       mode_eff;
  logic [29:0]      size_w;
  logic [SizeW-1:0] limit, size_sat, rcv_inc;
  logic             too_large, finish;
  logic [16:0]      idle_inc;
  logic [7:0]       b;

  assign pop     = q_valid_i & (~out_valid_q | ~out_stall_i);
  assign q_pop_o = pop;
  assign b       = q_item_i.data;

  // size from the registered area; the mode byte is taken live while it is the current header byte
  assign mode_eff = (hidx_q == 4'd7) ? b : mode_q;
  assign size_w   = (mode_eff == ModeMono || mode_eff == ModePartMono)
                    ? {1'b0, prod_q[31:3]} : prod_q[31:2];
  assign limit     = (maxpay_q > LimitCap) ? LimitCap : maxpay_q;
  assign size_sat  = (|size_w[29:SizeW]) ? '1 : size_w[SizeW-1:0];
  assign too_large = size_w > 30'(limit);
  assign idle_inc  = (idle_q == '1) ? idle_q : idle_q + 1'b1;
  assign rcv_inc   = rcv_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    hidx_d   = hidx_q;
    magic0_d = magic0_q;
    magic1_d = magic1_q;
    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    x_d      = x_q;
    y_d      = y_q;
    exp_d    = exp_q;
    rcv_d    = rcv_q;
    idle_d   = idle_q;
    ev       = EvNone;
    addr     = '0;
    data     = '0;
    done     = 1'b0;
    finish   = 1'b0;

    if (q_item_i.is_tick) begin
      if (phase_q == PhPayload) begin
        idle_d = idle_inc;
        if (idle_inc > {1'b0, timeout_q}) begin
          ev      = EvTimeout;
          phase_d = PhHunt;
          rcv_d   = '0;
        end
      end
    end else begin
      idle_d = '0;
      case (phase_q)
        PhHunt: begin
          if (q_item_i.is_start) begin
            phase_d  = PhHeader;
            hidx_d   = 4'd1;
            magic0_d = '0;
            magic1_d = '0;
            width_d  = '0;
            height_d = '0;
            mode_d   = '0;
            x_d      = '0;
            y_d      = '0;
            exp_d    = '0;
            rcv_d    = '0;
            ev       = EvHdrByte;
          end
        end
        PhHeader: begin
          ev     = EvHdrByte;
          hidx_d = hidx_q + 1'b1;
          case (hidx_q)
            4'd1:    magic0_d = b;
            4'd2:    magic1_d = b;
            4'd3:    width_d  = {b, width_q[7:0]};
            4'd4:    width_d  = {width_q[15:8], b};
            4'd5:    height_d = {b, height_q[7:0]};
            4'd6:    height_d = {height_q[15:8], b};
            4'd7:    mode_d   = b;
            4'd8:    x_d      = {b, x_q[7:0]};
            4'd9:    x_d      = {x_q[15:8], b};
            4'd10:   y_d      = {b, y_q[7:0]};
            default: y_d      = {y_q[15:8], b};
          endcase
          if (hidx_q == 4'd7) begin
            if (magic0_q != MagicP || magic1_q != MagicD) begin
              ev      = EvBadMagic;
              phase_d = PhHunt;
            end else if (b != ModeMono && b != ModeColor && b != ModePartMono
                         && b != ModePartCol) begin
              ev      = EvBadMode;
              phase_d = PhHunt;
            end else if (b != ModePartMono && b != ModePartCol) begin
              finish = 1'b1;
            end
          end else if (hidx_q >= 4'd11) begin
            finish = 1'b1;
          end
        end
        PhPayload: begin
          ev    = EvPayload;
          addr  = rcv_q[AddrW-1:0];
          data  = b;
          rcv_d = rcv_inc;
          if (rcv_inc >= exp_q) begin
            done    = 1'b1;
            phase_d = PhHunt;
            rcv_d   = '0;
          end
        end
        default: phase_d = PhHunt;
      endcase
    end

    if (finish) begin
      exp_d  = size_sat;
      rcv_d  = '0;
      idle_d = '0;
      if (too_large) begin
        ev      = EvTooLarge;
        phase_d = PhHunt;
      end else if (size_sat == '0) begin
        ev      = EvHdrOk;
        done    = 1'b1;
        phase_d = PhHunt;
      end else begin
        ev      = EvHdrOk;
        phase_d = PhPayload;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt;
      hidx_q    <= '0;
      magic0_q  <= '0;
      magic1_q  <= '0;
      width_q   <= '0;
      height_q  <= '0;
      mode_q    <= '0;
      x_q       <= '0;
      y_q       <= '0;
      exp_q     <= '0;
      rcv_q     <= '0;
      idle_q    <= '0;
      prod_q    <= '0;
      timeout_q <= TimeoutReset;
      maxpay_q  <= MaxPayloadReset;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        phase_q  <= phase_d;
        hidx_q   <= hidx_d;
        magic0_q <= magic0_d;
        magic1_q <= magic1_d;
        width_q  <= width_d;
        height_q <= height_d;
        mode_q   <= mode_d;
        x_q      <= x_d;
        y_q      <= y_d;
        exp_q    <= exp_d;
        rcv_q    <= rcv_d;
        idle_q   <= idle_d;
        // area tracks the header registers so it is ready for the last header byte
        prod_q   <= {16'd0, width_d} * {16'd0, height_d};
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CfgTimeout:    timeout_q <= cfg_data_i[15:0];
          CfgMaxPayload: maxpay_q  <= cfg_data_i;
          default:       ;
        endcase
      end
      if (pop)               out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      ev_q   <= ev;
      addr_q <= addr;
      data_q <= data;
      done_q <= done;
      fw_q   <= width_d;
      fh_q   <= height_d;
      fm_q   <= mode_d;
      fx_q   <= x_d;
      fy_q   <= y_d;
      size_q <= exp_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = ev_q;
  assign payload_addr_o = addr_q;
  assign payload_data_o = data_q;
  assign frame_done_o   = done_q;
  assign frame_width_o  = fw_q;
  assign frame_height_o = fh_q;
  assign frame_mode_o   = fm_q;
  assign frame_x_o      = fx_q;
  assign frame_y_o      = fy_q;
  assign payload_size_o = size_q;

endmodule

[hw/rtl/image_frame_receiver_top.sv]
// a beat enters the queue at its accepting edge and the result register loads when the
// back part pops it; throughput: one beat per cycle unless a stall holds the flow;
// the 4-entry queue lets input and output stall independently
// frame area is re-registered from the header fields after every beat, one 16x16 multiply
// reset (async, active low): hunting for start byte, header and counters zero,
// timeout 5000 ticks, max payload 77760 bytes; configuration writes are always ready
// depends on ifr_pkg, ifr_front, ifr_back
module image_frame_receiver_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      opcode_i,
  input  logic [7:0]                rx_byte_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic                      cfg_index_i,
  input  logic [ifr_pkg::SizeW-1:0] cfg_data_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [2:0]                event_res_o,
  output logic [ifr_pkg::AddrW-1:0] payload_addr_o,
  output logic [7:0]                payload_data_o,
  output logic                      frame_done_o,
  output logic [15:0]               frame_width_o,
  output logic [15:0]               frame_height_o,
  output logic [7:0]                frame_mode_o,
  output logic [15:0]               frame_x_o,
  output logic [15:0]               frame_y_o,
  output logic [ifr_pkg::SizeW-1:0] payload_size_o
);
  import ifr_pkg::*;

  logic  q_valid, q_pop;
  item_t q_item;

  assign cfg_ready_o = 1'b1;

  ifr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .opcode_i   (opcode_i),
    .rx_byte_i  (rx_byte_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  ifr_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (q_item),
    .q_pop_o        (q_pop),
    .cfg_valid_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .payload_addr_o (payload_addr_o),
    .payload_data_o (payload_data_o),
    .frame_done_o   (frame_done_o),
    .frame_width_o  (frame_width_o),
    .frame_height_o (frame_height_o),
    .frame_mode_o   (frame_mode_o),
    .frame_x_o      (frame_x_o),
    .frame_y_o      (frame_y_o),
    .payload_size_o (payload_size_o)
  );

  // a frame only completes on an accepted header or a payload byte
  a_done_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |-> (event_res_o == EvHdrOk || event_res_o == EvPayload))
    else $error("frame done on a wrong event");

  // payload addresses stay inside the announced size
  a_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EvPayload |-> {1'b0, payload_addr_o} < payload_size_o)
    else $error("payload address beyond frame size");

  // address and data are zero unless a payload byte is reported
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o != EvPayload |-> payload_addr_o == '0 && payload_data_o == '0)
    else $error("stray payload address or data");

endmodule
